/* hdl/assert_macros.svh */
// Assertion macros used by edd_core.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, masked while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also runs through reset
`define ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

/* hdl/edd_pkg.sv */
`timescale 1ns / 1ps
// Package for the encoder distance drive: widths, register indexes,
// reset values, ALU op codes and the word structs. No dependencies.
package edd_pkg;

  localparam int CNT_W_DEF  = 16;
  localparam int FRAC_DEF   = 16;
  // signed headroom of err*prop_gain + derr*deriv_gain over the count width
  localparam int PROD_EXTRA = 21;

  localparam int GAIN_W     = 18;
  localparam int SPD_W      = 8;
  localparam int TGT_W      = 16;
  localparam int PULSE_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd4;

  localparam logic [SPD_W-1:0]  MIN_SPEED_RST  = 8'd80;
  localparam logic [SPD_W-1:0]  MID_SPEED_RST  = 8'd100;
  localparam logic [SPD_W-1:0]  MAX_SPEED_RST  = 8'd120;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 18'd13107;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 18'd7;

  localparam logic CMD_START = 1'b0;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [SPD_W-1:0]  min_speed;
    logic [SPD_W-1:0]  mid_speed;
    logic [SPD_W-1:0]  max_speed;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [TGT_W-1:0]   cruise_count;
    logic [TGT_W-1:0]   ramp_count;
    logic               go_backward;
    logic [PULSE_W-1:0] right_pulses;
    logic [PULSE_W-1:0] left_pulses;
  } in_word_t;

  typedef struct packed {
    logic [SPD_W-1:0] right_drive;
    logic [SPD_W-1:0] left_drive;
    logic             drive_backward;
    logic             move_done;
  } res_t;

endpackage

/* hdl/edd_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result words.
// Depends on edd_pkg for field widths.
interface edd_in_if import edd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [TGT_W-1:0]   cruise_count;
  logic [TGT_W-1:0]   ramp_count;
  logic               go_backward;
  logic [PULSE_W-1:0] right_pulses;
  logic [PULSE_W-1:0] left_pulses;

  modport source (output valid, cmd, cruise_count, ramp_count, go_backward,
                  right_pulses, left_pulses, input ready);
  modport sink (input valid, cmd, cruise_count, ramp_count, go_backward,
                right_pulses, left_pulses, output ready);
endinterface

interface edd_out_if import edd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SPD_W-1:0] right_drive;
  logic [SPD_W-1:0] left_drive;
  logic             drive_backward;
  logic             move_done;

  modport source (output valid, right_drive, left_drive, drive_backward, move_done,
                  input ready);
  modport sink (input valid, right_drive, left_drive, drive_backward, move_done,
                output ready);
endinterface

/* hdl/edd_alu.sv */
`timescale 1ns / 1ps
// Shared add/subtract unit of the drive sequencer.
// Depends on edd_pkg for the op codes.
module edd_alu import edd_pkg::*; #(
  parameter int W = CNT_W_DEF + PROD_EXTRA
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         op_i,
  output logic [W-1:0] sum_o
);

  logic [W-1:0] b_eff;

  assign b_eff = (op_i == ALU_SUB) ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + W'(op_i == ALU_SUB);

endmodule

/* hdl/edd_core.sv */
`timescale 1ns / 1ps
// Sequencer and datapath of the drive: counts, PD correction by shift-add,
// ramp speed by restoring division, clamping. Depends on edd_pkg, edd_alu, assert_macros.svh.
`include "assert_macros.svh"

module edd_core import edd_pkg::*; #(
  parameter int COUNT_WIDTH    = CNT_W_DEF,
  parameter int GAIN_FRAC_BITS = FRAC_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output res_t     out_word_o
);

  localparam int CW   = COUNT_WIDTH;
  localparam int FRAC = GAIN_FRAC_BITS;
  localparam int PW   = CW + PROD_EXTRA;
  localparam int EW   = CW + 1;
  localparam int DW   = CW + 2;
  localparam int SW   = CW + 3;
  localparam int CRW  = PW - FRAC;
  localparam int AW   = (CW > TGT_W + 1) ? CW : TGT_W + 1;
  localparam int NW   = TGT_W + SPD_W;
  localparam int HW   = SPD_W + 3;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_DERR = 4'd2;
  localparam logic [3:0] S_ESUM = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_CORR = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_BASE = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;
  localparam logic [3:0] S_CLL  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]              state_r;
  logic [CW-1:0]           right_total_r, left_total_r;
  logic signed [EW-1:0]    last_err_r;
  logic [TGT_W-1:0]        cruise_r;
  logic [TGT_W:0]          total_r;
  logic                    dir_r, finished_r;
  logic [SPD_W-1:0]        held_right_r, held_left_r;
  logic signed [EW-1:0]    err_r;
  logic signed [DW-1:0]    derr_r;
  logic signed [SW-1:0]    esum_r;
  logic [PW-1:0]           acc_r;
  logic [4:0]              bit_r;
  logic signed [CRW-1:0]   corr_r;
  logic [TGT_W-1:0]        d_r, span_r;
  logic                    in_cruise_r;
  logic [NW-1:0]           rem_r;
  logic [SPD_W-1:0]        q_r;
  logic [2:0]              div_i_r;
  logic [SPD_W-1:0]        base_r;
  logic signed [HW-1:0]    hi_r;
  logic                    out_valid_r;
  res_t                    out_word_r;

  logic [CW:0]             r_sum, l_sum, avg_sum;
  logic [CW-1:0]           r_sat, l_sat, avg;
  logic [AW-1:0]           avg_x, d_full;
  logic                    avg_ge, avg_lt_cr;
  logic [TGT_W:0]          span_full;
  logic                    dneg;
  logic [SPD_W-1:0]        dmag;
  logic [NW-1:0]           num;
  logic signed [PW-1:0]    addend;
  logic [PW-1:0]           alu_a, alu_b, alu_sum;
  logic                    alu_op;
  logic [SPD_W-1:0]        base_nxt;
  logic signed [HW-1:0]    hi_nxt;

  // saturating wheel counts
  assign r_sum = {1'b0, right_total_r} + (CW+1)'(in_word_i.right_pulses);
  assign l_sum = {1'b0, left_total_r} + (CW+1)'(in_word_i.left_pulses);
  assign r_sat = r_sum[CW] ? {CW{1'b1}} : r_sum[CW-1:0];
  assign l_sat = l_sum[CW] ? {CW{1'b1}} : l_sum[CW-1:0];

  assign avg_sum   = {1'b0, right_total_r} + {1'b0, left_total_r};
  assign avg       = avg_sum[CW:1];
  assign avg_x     = AW'(avg);
  assign avg_ge    = avg_x >= AW'(total_r);
  assign avg_lt_cr = avg_x < AW'(cruise_r);
  assign d_full    = avg_x - AW'(cruise_r);
  assign span_full = total_r - {1'b0, cruise_r};

  assign dneg = cfg_i.mid_speed > cfg_i.min_speed;
  assign dmag = dneg ? (cfg_i.mid_speed - cfg_i.min_speed)
                     : (cfg_i.min_speed - cfg_i.mid_speed);
  assign num  = {{SPD_W{1'b0}}, d_r} * {{TGT_W{1'b0}}, dmag};

  // one gain bit of each product per cycle
  always_comb begin
    unique case ({cfg_i.prop_gain[bit_r], cfg_i.deriv_gain[bit_r]})
      2'b00: addend = '0;
      2'b10: addend = PW'(err_r);
      2'b01: addend = PW'(derr_r);
      2'b11: addend = PW'(esum_r);
    endcase
  end

  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    unique case (state_r)
      S_CHK: begin
        alu_a  = PW'(right_total_r);
        alu_b  = PW'(left_total_r);
        alu_op = ALU_SUB;
      end
      S_DERR: begin
        alu_a  = PW'(err_r);
        alu_b  = PW'(last_err_r);
        alu_op = ALU_SUB;
      end
      S_ESUM: begin
        alu_a = PW'(err_r);
        alu_b = PW'(derr_r);
      end
      S_MUL: begin
        alu_a = acc_r;
        alu_b = addend <<< bit_r;
      end
      S_CORR: begin
        // bias negative products so the shift truncates toward zero
        alu_a = acc_r;
        alu_b = acc_r[PW-1] ? {{(PW-FRAC){1'b0}}, {FRAC{1'b1}}} : '0;
      end
      S_DIV: begin
        alu_a  = PW'(rem_r);
        alu_b  = PW'({{SPD_W{1'b0}}, span_r} << div_i_r);
        alu_op = ALU_SUB;
      end
      S_CLR: begin
        alu_a  = PW'(base_r);
        alu_b  = PW'(corr_r);
        alu_op = ALU_SUB;
      end
      S_CLL: begin
        alu_a = PW'(base_r);
        alu_b = PW'(corr_r);
      end
      default: begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;
      end
    endcase
  end

  edd_alu #(
    .W(PW)
  ) u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .op_i (alu_op),
    .sum_o(alu_sum)
  );

  assign base_nxt = in_cruise_r ? cfg_i.mid_speed
                  : (dneg ? cfg_i.mid_speed - q_r : cfg_i.mid_speed + q_r);
  assign hi_nxt   = in_cruise_r ? signed'(HW'(cfg_i.max_speed))
                  : signed'({2'b00, base_nxt, 1'b0} - HW'(cfg_i.min_speed));

  // low bound wins over high bound, then limit to the drive range
  function automatic logic [SPD_W-1:0] clamp_drive(input logic signed [PW-1:0] v,
                                                   input logic [SPD_W-1:0] lo,
                                                   input logic signed [HW-1:0] hi);
    logic signed [PW-1:0] lo_x;
    logic signed [PW-1:0] hi_x;
    logic signed [PW-1:0] t;
    lo_x = signed'(PW'(lo));
    hi_x = PW'(hi);
    if (v < lo_x) begin
      t = lo_x;
    end else if (v > hi_x) begin
      t = hi_x;
    end else begin
      t = v;
    end
    if (t < 0) begin
      return '0;
    end else if (t > signed'(PW'(255))) begin
      return {SPD_W{1'b1}};
    end else begin
      return t[SPD_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      right_total_r <= '0;
      left_total_r  <= '0;
      last_err_r    <= '0;
      cruise_r      <= '0;
      total_r       <= '0;
      dir_r         <= 1'b0;
      finished_r    <= 1'b1;
      held_right_r  <= '0;
      held_left_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // S_FIN reloads the output register on its own
      if (out_valid_r && out_ready_i && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_word_i.cmd == CMD_START) begin
              right_total_r <= '0;
              left_total_r  <= '0;
              last_err_r    <= '0;
              cruise_r      <= in_word_i.cruise_count;
              total_r       <= {1'b0, in_word_i.cruise_count} + {1'b0, in_word_i.ramp_count};
              dir_r         <= in_word_i.go_backward;
              state_r       <= S_CHK;
            end else if (finished_r) begin
              state_r <= S_FIN;
            end else begin
              right_total_r <= r_sat;
              left_total_r  <= l_sat;
              state_r       <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (avg_ge) begin
            finished_r <= 1'b1;
            state_r    <= S_FIN;
          end else begin
            err_r       <= alu_sum[EW-1:0];
            d_r         <= d_full[TGT_W-1:0];
            span_r      <= span_full[TGT_W-1:0];
            in_cruise_r <= avg_lt_cr;
            state_r     <= S_DERR;
          end
        end
        S_DERR: begin
          derr_r  <= alu_sum[DW-1:0];
          rem_r   <= num;
          state_r <= S_ESUM;
        end
        S_ESUM: begin
          esum_r  <= alu_sum[SW-1:0];
          acc_r   <= '0;
          bit_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r <= alu_sum;
          if (bit_r == 5'(GAIN_W - 1)) begin
            state_r <= S_CORR;
          end else begin
            bit_r <= bit_r + 5'd1;
          end
        end
        S_CORR: begin
          corr_r     <= alu_sum[PW-1:FRAC];
          last_err_r <= err_r;
          q_r        <= '0;
          div_i_r    <= 3'd7;
          state_r    <= in_cruise_r ? S_BASE : S_DIV;
        end
        S_DIV: begin
          if (!alu_sum[PW-1]) begin
            rem_r        <= alu_sum[NW-1:0];
            q_r[div_i_r] <= 1'b1;
          end
          if (div_i_r == 3'd0) begin
            state_r <= S_BASE;
          end else begin
            div_i_r <= div_i_r - 3'd1;
          end
        end
        S_BASE: begin
          base_r  <= base_nxt;
          hi_r    <= hi_nxt;
          state_r <= S_CLR;
        end
        S_CLR: begin
          held_right_r <= clamp_drive(signed'(alu_sum), cfg_i.min_speed, hi_r);
          state_r      <= S_CLL;
        end
        S_CLL: begin
          held_left_r <= clamp_drive(signed'(alu_sum), cfg_i.min_speed, hi_r);
          finished_r  <= 1'b0;
          state_r     <= S_FIN;
        end
        S_FIN: begin
          // wait for the output register to free up
          if (!out_valid_r || out_ready_i) begin
            out_word_r.right_drive    <= held_right_r;
            out_word_r.left_drive     <= held_left_r;
            out_word_r.drive_backward <= dir_r;
            out_word_r.move_done      <= finished_r;
            out_valid_r               <= 1'b1;
            state_r                   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_r == S_IDLE);
  assign out_valid_o = out_valid_r;
  assign out_word_o  = out_word_r;

  `ASSERT_CLK(a_mul_bit_range, clk, rst_n, (state_r == S_MUL |-> bit_r < 5'(GAIN_W)), "multiply bit counter out of range")
  `ASSERT_CLK(a_div_rem_bound, clk, rst_n, (state_r == S_DIV |-> ({1'b0, rem_r} < ({9'd0, span_r} << ({1'b0, div_i_r} + 4'd1)))), "division remainder out of bound")
  `ASSERT_CLK(a_done_holds, clk, rst_n, (state_r == S_CHK && avg_ge |=> $stable(held_right_r) && $stable(held_left_r) && finished_r), "finished move changed the held speeds")
  `ASSERT_CLK(a_fin_waits, clk, rst_n, (state_r == S_FIN && out_valid_r && !out_ready_i |=> state_r == S_FIN && out_valid_r), "result word overwritten while stalled")
  `ASSERT_RST(a_reset_idle, clk, (!rst_n |=> state_r == S_IDLE && !out_valid_r), "not idle after reset")

endmodule

/* hdl/encoder_distance_drive_pd.sv */
`timescale 1ns / 1ps
// Top level of the encoder distance drive: configuration registers,
// channel hookup. Depends on edd_pkg, edd_if, edd_core.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    cmd, cruise_count, ramp_count, go_backward, pulses
//   out_ch    out   valid/ready    right_drive, left_drive, drive_backward, move_done
//   cfg_*     in    cfg_we only    cfg_index, cfg_wdata
//
// One word at a time on the shared adder: the sequencer checks the counts, forms
// the error terms, runs the shift-add gain multiply, in the ramp also the restoring
// divide, clamps both drives and loads the result word. An ended move loads it from
// the check; a tick after done skips the check. in_ready rises as the word is loaded.
// A stalled output holds the sequencer in its last step; reset is synchronous.
module encoder_distance_drive_pd import edd_pkg::*; #(
  parameter int COUNT_WIDTH    = CNT_W_DEF,
  parameter int GAIN_FRAC_BITS = FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  edd_in_if.sink                in_ch,
  edd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [SPD_W-1:0]  min_speed_r, mid_speed_r, max_speed_r;
  logic [GAIN_W-1:0] prop_gain_r, deriv_gain_r;
  cfg_t              cfg;
  in_word_t          in_word;
  res_t              out_word;
  logic              out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r  <= MIN_SPEED_RST;
      mid_speed_r  <= MID_SPEED_RST;
      max_speed_r  <= MAX_SPEED_RST;
      prop_gain_r  <= PROP_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_SPEED:  min_speed_r  <= cfg_wdata[SPD_W-1:0];
        REG_MID_SPEED:  mid_speed_r  <= cfg_wdata[SPD_W-1:0];
        REG_MAX_SPEED:  max_speed_r  <= cfg_wdata[SPD_W-1:0];
        REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.min_speed  = min_speed_r;
  assign cfg.mid_speed  = mid_speed_r;
  assign cfg.max_speed  = max_speed_r;
  assign cfg.prop_gain  = prop_gain_r;
  assign cfg.deriv_gain = deriv_gain_r;

  assign in_word.cmd          = in_ch.cmd;
  assign in_word.cruise_count = in_ch.cruise_count;
  assign in_word.ramp_count   = in_ch.ramp_count;
  assign in_word.go_backward  = in_ch.go_backward;
  assign in_word.right_pulses = in_ch.right_pulses;
  assign in_word.left_pulses  = in_ch.left_pulses;

  edd_core #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ch.ready),
    .out_word_o (out_word)
  );

  assign out_ch.valid          = out_valid;
  assign out_ch.right_drive    = out_word.right_drive;
  assign out_ch.left_drive     = out_word.left_drive;
  assign out_ch.drive_backward = out_word.drive_backward;
  assign out_ch.move_done      = out_word.move_done;

endmodule
